[design/sli_pkg.sv]
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants for the sorted list block
// Holds the table capacity, operation and status codes, and the command
// structure broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int Capacity    = 16;
  localparam int CntW        = $clog2(Capacity + 1);
  localparam int ValueW      = 32;
  localparam int EntryCountW = 5;

  typedef enum logic {
    OpInsert = 1'b0,
    OpDelete = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StFull     = 2'd1,
    StNotFound = 2'd2
  } status_e;

  // Command broadcast to all cells in the cycle a transaction is accepted.
  typedef struct packed {
    logic                     valid;
    op_e                      op;
    logic                     full;
    logic                     found;
    logic signed [ValueW-1:0] value;
  } cmd_t;

  // Compare flags that a cell reports to its neighbor and to the top level.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

[design/sli_cell.sv]
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted table
// Holds one entry, compares it with the broadcast value, and on a write
// keeps its entry, takes the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module sli_cell import sli_pkg::*; (
  input  logic                     clk_i,
  input  cmd_t                     cmd_i,
  input  logic                     occupied_i,   // slot index below the count
  input  logic                     left_lt_i,    // left neighbor is below value
  input  logic signed [ValueW-1:0] left_value_i,
  input  logic signed [ValueW-1:0] right_value_i,
  output cell_flags_t              flags_o,
  output logic signed [ValueW-1:0] value_o,
  output logic signed [ValueW-1:0] value_next_o
);

  logic signed [ValueW-1:0] value_q, value_d;
  logic                     write_en;

  assign flags_o.lt = occupied_i && (value_q < cmd_i.value);
  assign flags_o.eq = occupied_i && (value_q == cmd_i.value);

  assign write_en = cmd_i.valid &&
                    (((cmd_i.op == OpInsert) && !cmd_i.full) ||
                     ((cmd_i.op == OpDelete) && cmd_i.found));

  always_comb begin
    value_d = value_q;
    // Slots before the operation point keep their entry.
    if (write_en && !flags_o.lt) begin
      if (cmd_i.op == OpInsert) begin
        value_d = left_lt_i ? cmd_i.value : left_value_i;
      end else begin
        value_d = right_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o      = value_q;
  assign value_next_o = value_d;

endmodule

[design/sorted_list_insert_delete.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_delete: sorted table with insert and delete
// Keeps up to Capacity signed 32-bit entries in ascending order in a chain
// of compare-and-shift cells, and answers each transaction with a status,
// the entry count and the smallest entry.
// ----------------------------------------------------------------------------
//
// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   value[31:0]                                op[0]
// m_axis    out  entry_count[4:0], smallest_value[36:5]     status[1:0]
//
// One transaction is taken per cycle: every cell compares its entry with the
// value in the same cycle and shifts by one slot, so the whole table updates
// together. The result sits in an output register in the next cycle.
// A new transaction is accepted while the result register is empty or being
// taken; a stalled output holds the input side off.
// Reset clears the entry count and the output valid; entry data is not reset
// because slots at or beyond the count are never read.
//
module sorted_list_insert_delete import sli_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // value[31:0]
  input  logic        s_axis_tuser_i,   // op[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // entry_count[4:0], smallest_value[36:5], zeros
  output logic [1:0]  m_axis_tuser_o    // status[1:0]
);

  logic                     s_accept;
  logic [CntW-1:0]          count_q, count_d;
  cmd_t                     cmd;
  cell_flags_t              flags [Capacity];
  logic [Capacity-1:0]      lt_vec, eq_vec;
  logic signed [ValueW-1:0] cell_value [Capacity];
  logic signed [ValueW-1:0] cell_next [Capacity];
  status_e                  status;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [EntryCountW-1:0]   out_count_q;
  logic signed [ValueW-1:0] out_smallest_q;

  // The input side is open whenever the result register can take a new result.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign cmd.valid = s_accept;
  assign cmd.op    = op_e'(s_axis_tuser_i);
  assign cmd.value = s_axis_tdata_i;
  assign cmd.full  = (count_q >= CntW'(Capacity));
  assign cmd.found = |eq_vec;

  // The chain of cells. Cell zero sees a virtual left neighbor below every
  // value, so an insert at the front takes the new value. The last cell has
  // no right neighbor; what it takes on a delete lies beyond the count.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic                     left_lt;
    logic signed [ValueW-1:0] left_value, right_value;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_value = cmd.value;
    end else begin : g_mid
      assign left_lt    = flags[i-1].lt;
      assign left_value = cell_value[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
    end

    sli_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .occupied_i    (CntW'(i) < count_q),
      .left_lt_i     (left_lt),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .flags_o       (flags[i]),
      .value_o       (cell_value[i]),
      .value_next_o  (cell_next[i])
    );

    assign lt_vec[i] = flags[i].lt;
    assign eq_vec[i] = flags[i].eq;
  end

  // Status and count of the accepted transaction.
  always_comb begin
    status  = StDone;
    count_d = count_q;
    if (cmd.op == OpInsert) begin
      if (cmd.full) begin
        status = StFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (!cmd.found) begin
        status = StNotFound;
      end else begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (s_accept) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_accept;
    end
  end

  // Result payload; the smallest entry is the front cell's next value, or zero when empty.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_status_q   <= status;
      out_count_q    <= EntryCountW'(count_d);
      out_smallest_q <= (count_d != '0) ? cell_next[0] : '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {3'b000, out_smallest_q, out_count_q};

  // The count never runs past the table size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count exceeds capacity");

  // Entries stay sorted, so the below-value flags form a prefix of the chain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lt_vec >> 1) & ~lt_vec) == '0)
    else $error("below-value flags are not a prefix; table out of order");

  // An insert into a table with room grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd.op == OpInsert && !cmd.full) |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the entry count");

  // A refused insert reports a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd.op == OpInsert && cmd.full) |=> out_status_q == StFull)
    else $error("refused insert did not report full");

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_list_insert_delete
// Drives insert and delete transactions into the slave stream and checks every
// result against a queue-based model of the sorted table. The run covers a
// directed opening and random phases with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import sli_pkg::*;

  // Expected result of one transaction, in the block's field widths.
  typedef struct packed {
    status_e                  status;
    logic [EntryCountW-1:0]   entry_count;
    logic signed [ValueW-1:0] smallest_value;
  } table_result_t;

  // Model of the sorted table plus the queue of results still to arrive.
  // Each accepted transaction updates the model at once, so the expected
  // result is fixed at acceptance time and compared in order later.
  class sorted_table_scoreboard;
    logic signed [ValueW-1:0] entries_q[$];
    table_result_t            expected_q[$];
    int                       mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    // Random entry currently held, so deletes can hit real values.
    function logic [ValueW-1:0] pick_held();
      if (entries_q.size() == 0) return '0;
      return entries_q[$urandom_range(entries_q.size() - 1)];
    endfunction

    // Applies one accepted transaction to the model and queues its result.
    function void note_transaction(op_e op, logic signed [ValueW-1:0] value);
      table_result_t res;
      int            pos;
      pos = 0;
      if (op == OpInsert) begin
        if (entries_q.size() >= Capacity) begin
          res.status = StFull;
        end else begin
          // The new value goes before the first entry not below it.
          while (pos < entries_q.size() && entries_q[pos] < value) pos++;
          entries_q.insert(pos, value);
          res.status = StDone;
        end
      end else begin
        while (pos < entries_q.size() && entries_q[pos] != value) pos++;
        if (pos >= entries_q.size()) begin
          res.status = StNotFound;
        end else begin
          entries_q.delete(pos);
          res.status = StDone;
        end
      end
      res.entry_count    = EntryCountW'(entries_q.size());
      res.smallest_value = (entries_q.size() > 0) ? entries_q[0] : '0;
      expected_q.push_back(res);
    endfunction

    // Compares one accepted result with the oldest expectation.
    task check_result(status_e status, logic [EntryCountW-1:0] entry_count,
                      logic signed [ValueW-1:0] smallest_value);
      table_result_t exp_res;
      if (expected_q.size() == 0) begin
        report("result arrived with no transaction outstanding");
      end else begin
        exp_res = expected_q.pop_front();
        if (status !== exp_res.status)
          report($sformatf("status got %0d expected %0d", status, exp_res.status));
        if (entry_count !== exp_res.entry_count)
          report($sformatf("entry_count got %0d expected %0d",
                           entry_count, exp_res.entry_count));
        if (smallest_value !== exp_res.smallest_value)
          report($sformatf("smallest_value got %0d expected %0d",
                           smallest_value, exp_res.smallest_value));
      end
    endtask
  endclass

  localparam int StallLimit = 4000;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i  = '0;    // value[31:0]
  logic        s_axis_tuser_i  = 1'b0;  // op[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;          // entry_count[4:0], smallest_value[36:5], zeros
  logic [1:0]  m_axis_tuser_o;          // status[1:0]

  int sender_idle_pct   = 0;
  int receiver_stall_pct = 0;
  int quiet_cycles      = 0;

  sorted_table_scoreboard table_sb = new();

  sorted_list_insert_delete uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: ready is redrawn every cycle, so stalls land on any phase of
  // the output register, including the cycle a new result is loaded.
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Monitor for both channels. All inputs change by nonblocking assignment,
  // so the values read here are the ones the block saw at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      table_sb.check_result(status_e'(m_axis_tuser_o), m_axis_tdata_o[4:0],
                            m_axis_tdata_o[36:5]);
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      table_sb.note_transaction(op_e'(s_axis_tuser_i), s_axis_tdata_i);
    end
  end

  // Watchdog: a long stretch with no transaction on either side means the
  // block has hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("sorted_list_insert_delete test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one transaction, with random gaps first, and returns at the edge
  // where it is accepted.
  task send(op_e op, logic [31:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Operand mix: mostly a narrow band near zero and held entries so that
  // duplicates and hits on delete are common, plus extremes and full-range
  // values so every bit toggles.
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return $signed($urandom_range(8)) - 4;
    if (sel < 7) return table_sb.pick_held();
    if (sel == 7) return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return $urandom;
  endfunction

  initial begin
    int phase_idle[4];
    int phase_stall[4];
    int insert_pct;

    phase_idle  = '{0, 64, 0, 13};
    phase_stall = '{0, 0, 64, 13};

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: delete on an empty table, extremes and duplicates,
    // delete of a duplicate and of an absent value, then fill to capacity,
    // refuse an insert on the full table and delete both ends.
    send(OpDelete, 32'd7);
    send(OpInsert, 32'h7FFF_FFFF);
    send(OpInsert, 32'h8000_0000);
    send(OpInsert, 32'h0000_0000);
    send(OpInsert, 32'hFFFF_FFFF);
    send(OpInsert, 32'h0000_0000);
    send(OpDelete, 32'h0000_0000);
    send(OpDelete, 32'd5);
    send(OpInsert, 32'hAAAA_AAAA);
    send(OpInsert, 32'h5555_5555);
    for (int i = 0; i < 10; i++) send(OpInsert, $urandom);
    send(OpInsert, 32'd3);
    send(OpDelete, 32'h7FFF_FFFF);
    send(OpDelete, 32'h8000_0000);

    // Random phases. Each phase leans toward inserts in its first half and
    // toward deletes in the second, so the table swings between full and
    // empty under every mix of gaps and stalls.
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = phase_idle[p];
      receiver_stall_pct = phase_stall[p];
      for (int k = 0; k < 100; k++) begin
        insert_pct = (k < 50) ? 70 : 30;
        send(($urandom_range(99) < insert_pct) ? OpInsert : OpDelete, pick_value());
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: the watchdog bounds this wait.
    while (table_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (table_sb.mismatches == 0) begin
      $display("sorted_list_insert_delete test passed");
    end else begin
      $display("sorted_list_insert_delete test failed");
    end
    $finish;
  end

endmodule

[sorted_list_insert_delete.f]
design/sli_pkg.sv
design/sli_cell.sv
design/sorted_list_insert_delete.sv
tb/tb.sv
